[hw/rtl/oflt_pkg.sv]
// Shared types and constants of the face line triangulator.
package oflt_pkg;

   // Default widths and sizes
   localparam int INDEX_WIDTH_DEF = 24;
   localparam int QUEUE_DEPTH_DEF = 2;
   localparam int OUT_INDEX_WIDTH = 24;
   localparam int MATERIAL_WIDTH  = 16;
   localparam int CHAR_WIDTH      = 8;
   localparam int CORNER_SLOTS    = 9;

   // Character codes
   localparam logic [CHAR_WIDTH-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_WIDTH-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_WIDTH-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CH_HASH  = 8'h23;
   localparam logic [CHAR_WIDTH-1:0] CH_SLASH = 8'h2F;
   localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;

   // Result kinds
   typedef enum logic [2:0] {
      KIND_VERTEX   = 3'd0,
      KIND_TEXTURE  = 3'd1,
      KIND_NORMAL   = 3'd2,
      KIND_MATERIAL = 3'd3,
      KIND_ERROR    = 3'd4
   } kind_type;

   // Control part of one job handed from the parser to the emitter
   typedef struct packed {
      logic                      is_error;
      logic                      has_texture;
      logic                      has_normal;
      logic                      material_valid;
      logic [MATERIAL_WIDTH-1:0] material_index;
   } job_ctrl_type;

endpackage

[hw/rtl/oflt_front.sv]
// Byte parser: number accumulation, corner tracking and job generation.
module oflt_front import oflt_pkg::*; #(
   parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       fire,
   input  logic [CHAR_WIDTH-1:0]                      char_code,
   input  logic                                       material_valid,
   input  logic [MATERIAL_WIDTH-1:0]                  material_index,
   output logic                                       job_push,
   output job_ctrl_type                               job_ctrl,
   output logic [CORNER_SLOTS-1:0][INDEX_WIDTH-1:0]   job_indices
);

   localparam int PW = INDEX_WIDTH + 4;
   localparam logic [INDEX_WIDTH-1:0] INDEX_MAX = {INDEX_WIDTH{1'b1}};

   logic [CORNER_SLOTS-1:0][INDEX_WIDTH-1:0] idx_ff, idx_in;
   logic [1:0]             cc_ff, cc_in;
   logic [1:0]             kc_ff, kc_in;
   logic                   ht_ff, ht_in;
   logic                   hn_ff, hn_in;
   logic                   njr_ff, njr_in;
   logic [INDEX_WIDTH-1:0] acc_ff, acc_in;
   logic                   innum_ff, innum_in;
   logic                   skip_ff, skip_in;

   logic                                     is_digit, is_sep, is_slash;
   logic                                     fail, emit, stop;
   logic [INDEX_WIDTH-1:0]                   acc_base;
   logic [PW-1:0]                            acc_ext, prod;
   logic [3:0]                               digit, slot;
   logic [CORNER_SLOTS-1:0][INDEX_WIDTH-1:0] idx_v;
   logic [1:0]                               kc_v, cc_v;
   logic                                     ht_v, hn_v, njr_v;

   // Classify the byte
   assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
   assign is_slash = (char_code == CH_SLASH);
   assign is_sep   = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
                     (char_code == CH_CR) || (char_code == CH_LF) ||
                     (char_code == CH_NUL) || (char_code == CH_HASH);

   // Decimal step: times ten plus digit
   assign digit    = 4'(char_code - CH_ZERO);
   assign acc_base = innum_ff ? acc_ff : '0;
   assign acc_ext  = PW'(acc_base);
   assign prod     = (acc_ext << 3) + (acc_ext << 1) + PW'(digit);

   // Next state of the parser
   always_comb begin
      idx_v    = idx_ff;
      kc_v     = kc_ff;
      cc_v     = cc_ff;
      ht_v     = ht_ff;
      hn_v     = hn_ff;
      njr_v    = njr_ff;
      acc_in   = acc_ff;
      innum_in = innum_ff;
      skip_in  = skip_ff;
      fail     = 1'b0;
      emit     = 1'b0;
      stop     = 1'b0;
      slot     = 4'(kc_ff) * 4'd3 + 4'(cc_ff);
      if (skip_ff) begin
         // drop bytes until end of line
      end else if (is_digit) begin
         if (!innum_ff && kc_ff == 2'd3) begin
            fail = 1'b1;
         end else begin
            innum_in = 1'b1;
            if (prod[PW-1:INDEX_WIDTH] != '0) begin
               acc_in = INDEX_MAX;
               fail   = 1'b1;
            end else begin
               acc_in = prod[INDEX_WIDTH-1:0];
            end
         end
      end else begin
         // close a pending number
         if (innum_ff) begin
            innum_in = 1'b0;
            acc_in   = '0;
            if (acc_ff == '0 || kc_ff == 2'd3 || cc_ff == 2'd3) begin
               fail = 1'b1;
               stop = 1'b1;
            end else begin
               for (int s = 0; s < CORNER_SLOTS; s++) begin
                  if (4'(s) == slot) idx_v[s] = acc_ff;
               end
               njr_v = 1'b1;
               kc_v  = kc_ff + 2'd1;
               if (cc_ff == 2'd0 && kc_v == 2'd2) ht_v = 1'b1;
               else if (cc_ff == 2'd0 && kc_v == 2'd3) hn_v = 1'b1;
            end
         end
         if (!stop) begin
            if (is_slash) begin
               if (kc_v == 2'd3) begin
                  fail = 1'b1;
               end else if (!njr_v && (kc_v == 2'd0 || (kc_v == 2'd1 && ht_v) ||
                                       (kc_v == 2'd2 && hn_v))) begin
                  fail = 1'b1;
               end else begin
                  if (!njr_v) kc_v = kc_v + 2'd1;
                  njr_v = 1'b0;
               end
            end else if (is_sep) begin
               if (kc_v != 2'd0 && ((ht_v && kc_v < 2'd2) || (hn_v && kc_v < 2'd3))) begin
                  fail = 1'b1;
               end else begin
                  if (kc_v != 2'd0) begin
                     cc_v = cc_v + 2'd1;
                     kc_v = 2'd0;
                     if (cc_v == 2'd3) begin
                        emit = 1'b1;
                        cc_v = 2'd2;
                     end
                  end
                  njr_v = 1'b0;
                  if (char_code == CH_HASH) skip_in = 1'b1;
               end
            end else begin
               fail = 1'b1;
            end
         end
      end
      if (fail) skip_in = 1'b1;

      // shift the fan: third corner becomes the second
      idx_in = idx_v;
      if (emit) begin
         for (int k = 0; k < 3; k++) begin
            idx_in[k*3+1] = idx_v[k*3+2];
         end
      end
      kc_in  = kc_v;
      cc_in  = cc_v;
      ht_in  = ht_v;
      hn_in  = hn_v;
      njr_in = njr_v;

      // end of line clears all but the corner store
      if (char_code == CH_NUL) begin
         kc_in    = 2'd0;
         cc_in    = 2'd0;
         ht_in    = 1'b0;
         hn_in    = 1'b0;
         njr_in   = 1'b0;
         acc_in   = '0;
         innum_in = 1'b0;
         skip_in  = 1'b0;
      end
   end

   // Job towards the queue
   assign job_push                = fire && (fail || emit);
   assign job_ctrl.is_error       = fail;
   assign job_ctrl.has_texture    = ht_v;
   assign job_ctrl.has_normal     = hn_v;
   assign job_ctrl.material_valid = material_valid;
   assign job_ctrl.material_index = material_index;
   assign job_indices             = idx_v;

   // Advance the parser on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         cc_ff    <= 2'd0;
         kc_ff    <= 2'd0;
         ht_ff    <= 1'b0;
         hn_ff    <= 1'b0;
         njr_ff   <= 1'b0;
         acc_ff   <= '0;
         innum_ff <= 1'b0;
         skip_ff  <= 1'b0;
      end else if (fire) begin
         idx_ff   <= idx_in;
         cc_ff    <= cc_in;
         kc_ff    <= kc_in;
         ht_ff    <= ht_in;
         hn_ff    <= hn_in;
         njr_ff   <= njr_in;
         acc_ff   <= acc_in;
         innum_ff <= innum_in;
         skip_ff  <= skip_in;
      end
   end

endmodule

[hw/rtl/oflt_queue.sv]
// Small job queue between the parser and the result emitter.
module oflt_queue import oflt_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             not_empty,
   output logic             full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign head_data = mem_ff[rd_ptr_ff];

   // Wrap pointers and track fill
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (push && !pop)      count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("job pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("job popped from an empty queue");

endmodule

[hw/rtl/oflt_back.sv]
// Result emitter: expands one job into its triangle, material or error results.
module oflt_back import oflt_pkg::*; #(
   parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     job_valid,
   input  job_ctrl_type                             job_ctrl,
   input  logic [CORNER_SLOTS-1:0][INDEX_WIDTH-1:0] job_indices,
   output logic                                     job_pop,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output kind_type                                 rsp_kind,
   output logic [OUT_INDEX_WIDTH-1:0]               rsp_first,
   output logic [OUT_INDEX_WIDTH-1:0]               rsp_second,
   output logic [OUT_INDEX_WIDTH-1:0]               rsp_third,
   output logic                                     rsp_last
);

   typedef enum logic [3:0] {
      PH_VERT = 4'b0001,
      PH_TEX  = 4'b0010,
      PH_NRM  = 4'b0100,
      PH_MAT  = 4'b1000
   } phase_type;

   phase_type                  phase_ff, phase_in, next_phase;
   logic                       valid_ff, valid_in;
   kind_type                   kind_ff, kind_v;
   logic [OUT_INDEX_WIDTH-1:0] first_ff, second_ff, third_ff;
   logic [OUT_INDEX_WIDTH-1:0] first_v, second_v, third_v;
   logic                       last_ff, more;
   logic                       load;

   function automatic logic [OUT_INDEX_WIDTH-1:0] to_out(input logic [INDEX_WIDTH-1:0] v);
      to_out = OUT_INDEX_WIDTH'({{OUT_INDEX_WIDTH{1'b0}}, v});
   endfunction

   assign load    = job_valid && (!valid_ff || rsp_ready);
   assign job_pop = load && !more;

   // Pick the result for the current phase
   always_comb begin
      kind_v     = KIND_VERTEX;
      first_v    = to_out(job_indices[0]);
      second_v   = to_out(job_indices[1]);
      third_v    = to_out(job_indices[2]);
      more       = 1'b0;
      next_phase = PH_VERT;
      case (phase_ff)
         PH_VERT: begin
            more       = job_ctrl.has_texture || job_ctrl.has_normal ||
                         job_ctrl.material_valid;
            next_phase = job_ctrl.has_texture ? PH_TEX :
                         job_ctrl.has_normal  ? PH_NRM : PH_MAT;
         end
         PH_TEX: begin
            kind_v     = KIND_TEXTURE;
            first_v    = to_out(job_indices[3]);
            second_v   = to_out(job_indices[4]);
            third_v    = to_out(job_indices[5]);
            more       = job_ctrl.has_normal || job_ctrl.material_valid;
            next_phase = job_ctrl.has_normal ? PH_NRM : PH_MAT;
         end
         PH_NRM: begin
            kind_v     = KIND_NORMAL;
            first_v    = to_out(job_indices[6]);
            second_v   = to_out(job_indices[7]);
            third_v    = to_out(job_indices[8]);
            more       = job_ctrl.material_valid;
            next_phase = PH_MAT;
         end
         PH_MAT: begin
            kind_v   = KIND_MATERIAL;
            first_v  = OUT_INDEX_WIDTH'(job_ctrl.material_index);
            second_v = '0;
            third_v  = '0;
         end
         default: begin
            kind_v   = KIND_MATERIAL;
            first_v  = '0;
            second_v = '0;
            third_v  = '0;
         end
      endcase
      if (job_ctrl.is_error) begin
         kind_v     = KIND_ERROR;
         first_v    = '0;
         second_v   = '0;
         third_v    = '0;
         more       = 1'b0;
         next_phase = PH_VERT;
      end
   end

   // Control of the output register and phase
   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      if (load) begin
         valid_in = 1'b1;
         phase_in = more ? next_phase : PH_VERT;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= PH_VERT;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   // Hold payload until the next load
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= kind_v;
         first_ff  <= first_v;
         second_ff <= second_v;
         third_ff  <= third_v;
         last_ff   <= !more;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_first  = first_ff;
   assign rsp_second = second_ff;
   assign rsp_third  = third_ff;
   assign rsp_last   = last_ff;

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff == KIND_ERROR |-> last_ff)
      else $error("error result not marked last");

   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> valid_ff && last_ff)
      else $error("job retired without a last result");

   a_phase_needs_job: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_VERT |-> job_valid)
      else $error("mid-job phase without a job at the queue head");

endmodule

[hw/rtl/obj_face_line_triangulator.sv]
// Top level of the face line parser with fan triangulation.
//
//   Channel | Direction | Handshake            | Contents
//   req     | in        | req_tvalid/tready    | one byte of the face line
//   rsp     | out       | rsp_tvalid/tready    | triangle, material or error result
//
// One byte is taken per cycle while the job queue has room. A corner that closes
// a fan triangle, or an error, turns into one job; the emitter drains it one result
// at a time (1 to 4 results) through a registered output, so a long run of triangles
// is bounded by the emitter and the QUEUE_DEPTH-entry queue. Reset is synchronous
// and clears all control state and the corner store; no clearing pass follows it.
module obj_face_line_triangulator import oflt_pkg::*; #(
   parameter int INDEX_WIDTH = INDEX_WIDTH_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_code[7:0], material_index[23:8]
   input  logic [0:0]  req_tuser,   // material_valid[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // first_index[23:0], second_index[47:24],
                                    // third_index[71:48]
   output logic [2:0]  rsp_tuser,   // kind[2:0]
   output logic        rsp_tlast    // last_of_run
);

   localparam int JOB_W = $bits(job_ctrl_type) + CORNER_SLOTS * INDEX_WIDTH;

   logic                                     req_fire, q_full, q_not_empty;
   logic                                     job_push, job_pop;
   job_ctrl_type                             push_ctrl, head_ctrl;
   logic [CORNER_SLOTS-1:0][INDEX_WIDTH-1:0] push_idx, head_idx;
   logic [JOB_W-1:0]                         head_data;
   kind_type                                 rsp_kind;
   logic [OUT_INDEX_WIDTH-1:0]               rsp_first, rsp_second, rsp_third;

   assign req_tready = !q_full;
   assign req_fire   = req_tvalid && req_tready;

   oflt_front #(
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .fire           (req_fire),
      .char_code      (req_tdata[7:0]),
      .material_valid (req_tuser[0]),
      .material_index (req_tdata[23:8]),
      .job_push       (job_push),
      .job_ctrl       (push_ctrl),
      .job_indices    (push_idx)
   );

   oflt_queue #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data ({push_ctrl, push_idx}),
      .pop       (job_pop),
      .head_data (head_data),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   // Split the head entry back into its parts
   assign head_ctrl = head_data[JOB_W-1 -: $bits(job_ctrl_type)];
   assign head_idx  = head_data[CORNER_SLOTS*INDEX_WIDTH-1:0];

   oflt_back #(
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (q_not_empty),
      .job_ctrl    (head_ctrl),
      .job_indices (head_idx),
      .job_pop     (job_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_kind    (rsp_kind),
      .rsp_first   (rsp_first),
      .rsp_second  (rsp_second),
      .rsp_third   (rsp_third),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {rsp_third, rsp_second, rsp_first};
   assign rsp_tuser = rsp_kind;

endmodule

[sim/obj_face_line_triangulator_tb.sv]
// Self-checking testbench of the face line triangulator: byte stream in, fan triangles out.
module obj_face_line_triangulator_tb;
   import oflt_pkg::*;

   localparam int unsigned INDEX_LIMIT     = (32'd1 << INDEX_WIDTH_DEF) - 1;
   localparam int          IDLE_PERCENT    = 24;
   localparam int          RANDOM_BYTES    = 440;
   localparam int          HOLD_OFF_START  = 150;
   localparam int          HOLD_OFF_CYCLES = 300;
   localparam int          STEADY_FIRST    = 250;
   localparam int          STEADY_LAST     = 340;
   localparam int          WATCHDOG_LIMIT  = 4000;
   localparam int          DRAIN_CYCLES    = 16;

   // Ways in which a random face line is spoilt
   typedef enum int {
      FAULT_NONE,
      FAULT_ZERO_REF,
      FAULT_OVERFLOW,
      FAULT_BAD_BYTE,
      FAULT_MISSING_REF,
      FAULT_EXTRA_REF,
      FAULT_LEADING_SLASH,
      FAULT_FOURTH_REF,
      FAULT_COMMENT
   } line_fault_type;

   typedef struct {
      kind_type    kind;
      logic [23:0] first_index;
      logic [23:0] second_index;
      logic [23:0] third_index;
      logic        last_of_run;
   } face_result_type;

   // Parser state mirror and queue of results still to come
   class face_line_scoreboard;
      logic [23:0]     corner_ref[CORNER_SLOTS];
      int unsigned     corner_cnt;
      int unsigned     ref_cnt;
      bit              has_tex;
      bit              has_nrm;
      bit              just_read;
      bit              in_num;
      bit              skipping;
      logic [31:0]     accum;
      face_result_type expected[$];
      int unsigned     failures;

      function new();
         foreach (corner_ref[i]) corner_ref[i] = '0;
         failures = 0;
         clear_line();
      endfunction

      function void clear_line();
         corner_cnt = 0;
         ref_cnt    = 0;
         has_tex    = 1'b0;
         has_nrm    = 1'b0;
         just_read  = 1'b0;
         in_num     = 1'b0;
         skipping   = 1'b0;
         accum      = '0;
      endfunction

      function void add_result(kind_type kind, logic [23:0] a, logic [23:0] b,
                               logic [23:0] c);
         face_result_type r;
         r.kind         = kind;
         r.first_index  = a;
         r.second_index = b;
         r.third_index  = c;
         r.last_of_run  = 1'b0;
         expected.push_back(r);
      endfunction

      // One error result, then discard the line up to its end
      function void raise_error(logic [7:0] ch);
         add_result(KIND_ERROR, '0, '0, '0);
         expected[expected.size() - 1].last_of_run = 1'b1;
         skipping = 1'b1;
         if (ch == CH_NUL) clear_line();
      endfunction

      // Advance the parser by one accepted byte and queue what it produces
      function void note_byte(logic [7:0] ch, bit mat_valid, logic [15:0] mat_index);
         logic [31:0] val;
         if (skipping) begin
            if (ch == CH_NUL) clear_line();
            return;
         end
         // accumulate digits, saturating on overflow
         if (ch >= CH_ZERO && ch <= CH_NINE) begin
            if (!in_num) begin
               if (ref_cnt >= 3) begin
                  raise_error(ch);
                  return;
               end
               in_num = 1'b1;
               accum  = '0;
            end
            accum = accum * 10 + 32'(ch - CH_ZERO);
            if (accum > INDEX_LIMIT) begin
               accum = INDEX_LIMIT;
               raise_error(ch);
            end
            return;
         end
         // close a pending number into the corner store
         if (in_num) begin
            val    = accum;
            in_num = 1'b0;
            accum  = '0;
            if (val == 0 || ref_cnt >= 3 || corner_cnt >= 3) begin
               raise_error(ch);
               return;
            end
            corner_ref[ref_cnt * 3 + corner_cnt] = val[23:0];
            just_read = 1'b1;
            ref_cnt++;
            if (corner_cnt == 0 && ref_cnt == 2) has_tex = 1'b1;
            else if (corner_cnt == 0 && ref_cnt == 3) has_nrm = 1'b1;
         end
         if (ch == CH_SLASH) begin
            if (ref_cnt >= 3) begin
               raise_error(ch);
               return;
            end
            if (!just_read) begin
               if (ref_cnt == 0 || (ref_cnt == 1 && has_tex) || (ref_cnt == 2 && has_nrm)) begin
                  raise_error(ch);
                  return;
               end
               ref_cnt++;
            end
            just_read = 1'b0;
            return;
         end
         if (!(ch inside {CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_NUL, CH_HASH})) begin
            raise_error(ch);
            return;
         end
         // end the corner; from the third one on, emit a fan triangle
         if (ref_cnt > 0) begin
            if ((has_tex && ref_cnt < 2) || (has_nrm && ref_cnt < 3)) begin
               raise_error(ch);
               return;
            end
            corner_cnt++;
            ref_cnt = 0;
            if (corner_cnt >= 3) begin
               add_result(KIND_VERTEX, corner_ref[0], corner_ref[1], corner_ref[2]);
               if (has_tex) add_result(KIND_TEXTURE, corner_ref[3], corner_ref[4], corner_ref[5]);
               if (has_nrm) add_result(KIND_NORMAL, corner_ref[6], corner_ref[7], corner_ref[8]);
               if (mat_valid) add_result(KIND_MATERIAL, 24'(mat_index), '0, '0);
               expected[expected.size() - 1].last_of_run = 1'b1;
               for (int k = 0; k < 3; k++) corner_ref[k * 3 + 1] = corner_ref[k * 3 + 2];
               corner_cnt = 2;
            end
         end
         just_read = 1'b0;
         if (ch == CH_NUL) clear_line();
         else if (ch == CH_HASH) skipping = 1'b1;
      endfunction

      function void compare_field(string name, logic [23:0] want, logic [23:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      // Compare one accepted result with the oldest one queued
      function void check_result(logic [2:0] kind, logic [23:0] a, logic [23:0] b,
                                 logic [23:0] c, logic last);
         face_result_type e;
         if (expected.size() == 0) begin
            $error("result of kind %0d with none expected", kind);
            failures++;
            return;
         end
         e = expected.pop_front();
         compare_field("kind", 24'(e.kind), 24'(kind));
         compare_field("first_index", e.first_index, a);
         compare_field("second_index", e.second_index, b);
         compare_field("third_index", e.third_index, c);
         compare_field("last_of_run", 24'(e.last_of_run), 24'(last));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   face_line_scoreboard sb = new();
   int                  parsed_bytes = 0;
   int                  quiet_cycles = 0;
   bit                  steady_flow  = 1'b0;
   bit                  hold_off_req = 1'b0;

   obj_face_line_triangulator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Offer one byte, idling at random first outside the steady stretch, and hold it until taken
   task automatic send_byte(input logic [7:0] ch, input bit mat_valid,
                            input logic [15:0] mat_index);
      if (!steady_flow) begin
         while ($urandom_range(0, 99) < IDLE_PERCENT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {mat_index, ch};
      req_tuser  <= mat_valid;
      do @(posedge clock); while (!req_tready);
      parsed_bytes++;
      sb.note_byte(ch, mat_valid, mat_index);
   endtask

   task automatic send_line(input string text, input bit mat_valid,
                            input logic [15:0] mat_index);
      for (int i = 0; i < text.len(); i++) send_byte(text[i], mat_valid, mat_index);
      send_byte(CH_NUL, mat_valid, mat_index);
   endtask

   function automatic void add_text(ref logic [7:0] line[$], input string text);
      for (int i = 0; i < text.len(); i++) line.push_back(text[i]);
   endfunction

   function automatic int unsigned pick_index();
      case ($urandom_range(0, 19))
         0:       return INDEX_LIMIT;
         1, 2:    return $urandom_range(1, INDEX_LIMIT);
         3, 4, 5: return $urandom_range(100, 99999);
         default: return $urandom_range(1, 99);
      endcase
   endfunction

   function automatic logic [7:0] pick_separator();
      case ($urandom_range(0, 5))
         3:       return CH_TAB;
         4:       return CH_CR;
         5:       return CH_LF;
         default: return CH_SPACE;
      endcase
   endfunction

   function automatic logic [7:0] pick_bad_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255));
      while ((b >= CH_ZERO && b <= CH_NINE) ||
             (b inside {CH_SLASH, CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_HASH}));
      return b;
   endfunction

   // Build a face line of 3 to 6 corners in one of the four forms, spoilt now and then
   task automatic send_random_line();
      logic [7:0]     line[$];
      line_fault_type fault;
      int             form;
      int             corners;
      int             fault_at;
      bit             hit;
      bit             mat_valid;
      logic [15:0]    mat_index;
      mat_valid = 1'($urandom_range(0, 1));
      mat_index = 16'($urandom);
      form      = $urandom_range(0, 3);
      corners   = $urandom_range(3, 6);
      fault_at  = $urandom_range(0, corners - 1);
      fault     = ($urandom_range(0, 99) < 30) ? line_fault_type'($urandom_range(1, 8))
                                               : FAULT_NONE;
      if ($urandom_range(0, 7) == 0) line.push_back(pick_separator());
      for (int c = 0; c < corners; c++) begin
         hit = (c == fault_at);
         if (hit && fault == FAULT_LEADING_SLASH) line.push_back(CH_SLASH);
         if (hit && fault == FAULT_ZERO_REF) add_text(line, "0");
         else if (hit && fault == FAULT_OVERFLOW)
            add_text(line, $sformatf("%0d", $urandom_range(INDEX_LIMIT + 1, 99999999)));
         else add_text(line, $sformatf("%0d", pick_index()));
         // texture and normal references of the corner
         if (hit && fault == FAULT_MISSING_REF && c > 0) begin
            if (form == 3 && $urandom_range(0, 1)) add_text(line, $sformatf("/%0d", pick_index()));
         end else if (hit && (fault == FAULT_EXTRA_REF || fault == FAULT_FOURTH_REF)) begin
            add_text(line, $sformatf("/%0d/%0d", pick_index(), pick_index()));
            if (fault == FAULT_FOURTH_REF) add_text(line, $sformatf("/%0d", pick_index()));
         end else begin
            if (form == 1 || form == 3) add_text(line, $sformatf("/%0d", pick_index()));
            if (form == 2) add_text(line, "/");
            if (form >= 2) add_text(line, $sformatf("/%0d", pick_index()));
         end
         if (hit && fault == FAULT_BAD_BYTE) line.push_back(pick_bad_byte());
         if (hit && fault == FAULT_COMMENT) begin
            line.push_back(CH_HASH);
            repeat ($urandom_range(1, 6)) line.push_back(8'($urandom_range(1, 255)));
            break;
         end
         if (c < corners - 1 || $urandom_range(0, 1)) begin
            line.push_back(pick_separator());
            if ($urandom_range(0, 4) == 0) line.push_back(pick_separator());
         end
      end
      foreach (line[i]) send_byte(line[i], mat_valid, mat_index);
      send_byte(CH_NUL, mat_valid, mat_index);
   endtask

   // Short run of loose bytes, mostly from the legal set, then end of line
   task automatic send_noise_line();
      string legal_set;
      legal_set = "0123456789/ #";
      repeat ($urandom_range(0, 8)) begin
         if ($urandom_range(0, 1))
            send_byte(legal_set[$urandom_range(0, legal_set.len() - 1)],
                      1'($urandom_range(0, 1)), 16'($urandom));
         else send_byte(8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)), 16'($urandom));
      end
      send_byte(CH_NUL, 1'($urandom_range(0, 1)), 16'($urandom));
   endtask

   // Receiver: random back-pressure plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Check every result transaction; stop the run if traffic dries up
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_tvalid && rsp_tready)
               sb.check_result(rsp_tuser, rsp_tdata[23:0], rsp_tdata[47:24],
                               rsp_tdata[71:48], rsp_tlast);
            if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) quiet_cycles = 0;
            else quiet_cycles++;
         end
      end
      $display("** obj_face_line_triangulator: FAILED **");
      $finish;
   end

   initial begin
      bit hold_off_done;
      hold_off_done = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: all five result kinds, zero reference, bad byte, overflow
      send_line("1/2/3 4/5/6 7/8/9", 1'b1, 16'hFFFF);
      send_line("0", 1'b1, 16'h0000);
      send_byte(8'hFF, 1'b0, 16'h0000);
      send_byte(CH_NUL, 1'b0, 16'h0000);
      send_line("99999999", 1'b1, 16'h5A5A);

      // random lines, with a long receiver hold-off and a stretch of full rate
      parsed_bytes = 0;
      while (parsed_bytes < RANDOM_BYTES) begin
         steady_flow = (parsed_bytes >= STEADY_FIRST && parsed_bytes < STEADY_LAST);
         if (!hold_off_done && parsed_bytes >= HOLD_OFF_START) begin
            hold_off_req  = 1'b1;
            hold_off_done = 1'b1;
         end
         if ($urandom_range(0, 9) == 0) send_noise_line();
         else send_random_line();
      end
      steady_flow = 1'b0;
      req_tvalid <= 1'b0;

      // wait for the last results, then a short tail for strays
      while (sb.expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0) $display("** obj_face_line_triangulator: PASSED **");
      else $display("** obj_face_line_triangulator: FAILED **");
      $finish;
   end

endmodule
